// File: rtl/sdsc_pkg.sv
// Shared types, constants and the segment table for the seven-segment digit scan.
// No dependencies; every other file imports this package.
package sdsc_pkg;

  // Width of the input value and of one output port word.
  localparam int ValueW = 16;
  localparam int WordW  = 12;

  // Reciprocal of 1000 scaled by 2^22, rounded down, so the quotient estimate
  // is never too large and at most one too small.
  localparam logic [12:0] RECIP_1000 = 13'd4194;
  localparam logic [9:0]  DIV_1000   = 10'd1000;
  // Reciprocals for the hundreds (2^12 scale) and tens (2^11 scale) digits.
  localparam logic [5:0]  RECIP_100  = 6'd41;
  localparam logic [7:0]  RECIP_10   = 8'd205;
  localparam logic [6:0]  DIV_100    = 7'd100;
  localparam logic [3:0]  DIV_10     = 4'd10;

  // Active-low digit selects and the all-off word.
  localparam logic [3:0] SEL_HUNDREDS = 4'hD;
  localparam logic [3:0] SEL_TENS     = 4'hB;
  localparam logic [3:0] SEL_ONES     = 4'h7;
  localparam logic [WordW-1:0] WORD_ALL_OFF = 12'hFFF;

  // Position of a word within the six-word scan of one item.
  localparam logic [2:0] IDX_HUND = 3'd0;
  localparam logic [2:0] IDX_TENS = 3'd2;
  localparam logic [2:0] IDX_ONES = 3'd4;
  localparam logic [2:0] IDX_LAST = 3'd5;

  // Remainder of the value modulo 1000 plus the blanking flags.
  typedef struct packed {
    logic [9:0] rem;
    logic       ge10;
    logic       ge100;
  } mod_item_t;

  // Hundreds and tens digits plus the remainder modulo 100.
  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [6:0] rem;
    logic       ge10;
    logic       ge100;
  } dig_item_t;

  // Active-low segment pattern (dp,g,f,e,d,c,b,a) of a decimal digit.
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0: seg = 8'hC0;
      4'd1: seg = 8'hF9;
      4'd2: seg = 8'hA4;
      4'd3: seg = 8'hB0;
      4'd4: seg = 8'h99;
      4'd5: seg = 8'h92;
      4'd6: seg = 8'h82;
      4'd7: seg = 8'hF8;
      4'd8: seg = 8'h80;
      4'd9: seg = 8'h90;
      default: seg = 8'hFF;
    endcase
    return seg;
  endfunction

endpackage

// File: rtl/sdsc_mod1000.sv
// Three-stage pipeline that reduces the input value modulo 1000.
// Depends on sdsc_pkg.
module sdsc_mod1000 import sdsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [ValueW-1:0] up_value,
  output logic              dn_valid,
  input  logic              dn_ready,
  output mod_item_t         dn_item
);

  logic              s1_valid_r, s2_valid_r, s3_valid_r;
  logic              rdy1, rdy2, rdy3;
  logic [ValueW-1:0] s1_value_r;
  logic [6:0]        s1_q_r;
  logic              s1_ge10_r, s1_ge100_r;
  logic [10:0]       s2_rem_r;
  logic              s2_ge10_r, s2_ge100_r;
  mod_item_t         s3_item_r;
  logic [28:0]       q_prod;
  logic [16:0]       r_diff;
  logic [10:0]       r_fix;

  assign rdy3     = !s3_valid_r || dn_ready;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign up_ready = rdy1;

  // Quotient estimate, then remainder, then a single correction step.
  assign q_prod = 29'(up_value) * 29'(RECIP_1000);
  assign r_diff = 17'(s1_value_r) - 17'(s1_q_r) * 17'(DIV_1000);
  assign r_fix  = (s2_rem_r >= 11'(DIV_1000)) ? (s2_rem_r - 11'(DIV_1000)) : s2_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= up_valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      s1_value_r <= up_value;
      s1_q_r     <= q_prod[28:22];
      s1_ge10_r  <= (up_value >= 16'd10);
      s1_ge100_r <= (up_value >= 16'd100);
    end
    if (rdy2 && s1_valid_r) begin
      s2_rem_r   <= r_diff[10:0];
      s2_ge10_r  <= s1_ge10_r;
      s2_ge100_r <= s1_ge100_r;
    end
    if (rdy3 && s2_valid_r) begin
      s3_item_r.rem   <= r_fix[9:0];
      s3_item_r.ge10  <= s2_ge10_r;
      s3_item_r.ge100 <= s2_ge100_r;
    end
  end

  assign dn_valid = s3_valid_r;
  assign dn_item  = s3_item_r;

endmodule

// File: rtl/sdsc_digits.sv
// Three-stage pipeline that splits a remainder below 1000 into hundreds and tens digits.
// Depends on sdsc_pkg.
module sdsc_digits import sdsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  mod_item_t up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output dig_item_t dn_item
);

  logic        s4_valid_r, s5_valid_r, s6_valid_r;
  logic        rdy4, rdy5, rdy6;
  logic [9:0]  s4_rem_r;
  logic [3:0]  s4_hund_r;
  logic        s4_ge10_r, s4_ge100_r;
  dig_item_t   s5_item_r;
  dig_item_t   s6_item_r;
  logic [15:0] h_prod;
  logic [9:0]  h_diff;
  logic [14:0] t_prod;

  assign rdy6     = !s6_valid_r || dn_ready;
  assign rdy5     = !s5_valid_r || rdy6;
  assign rdy4     = !s4_valid_r || rdy5;
  assign up_ready = rdy4;

  assign h_prod = 16'(up_item.rem) * 16'(RECIP_100);
  assign h_diff = s4_rem_r - 10'(s4_hund_r) * 10'(DIV_100);
  assign t_prod = 15'(s5_item_r.rem) * 15'(RECIP_10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      if (rdy4) s4_valid_r <= up_valid;
      if (rdy5) s5_valid_r <= s4_valid_r;
      if (rdy6) s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && up_valid) begin
      s4_rem_r   <= up_item.rem;
      s4_hund_r  <= h_prod[15:12];
      s4_ge10_r  <= up_item.ge10;
      s4_ge100_r <= up_item.ge100;
    end
    if (rdy5 && s4_valid_r) begin
      s5_item_r.hund  <= s4_hund_r;
      s5_item_r.tens  <= 4'd0;
      s5_item_r.rem   <= h_diff[6:0];
      s5_item_r.ge10  <= s4_ge10_r;
      s5_item_r.ge100 <= s4_ge100_r;
    end
    if (rdy6 && s5_valid_r) begin
      s6_item_r.hund  <= s5_item_r.hund;
      s6_item_r.tens  <= t_prod[14:11];
      s6_item_r.rem   <= s5_item_r.rem;
      s6_item_r.ge10  <= s5_item_r.ge10;
      s6_item_r.ge100 <= s5_item_r.ge100;
    end
  end

  assign dn_valid = s6_valid_r;
  assign dn_item  = s6_item_r;

endmodule

// File: rtl/sdsc_scan_out.sv
// Holds one set of digits and emits its port words, one per cycle unless out_ready stalls, into the output register.
// Depends on sdsc_pkg.
module sdsc_scan_out import sdsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  dig_item_t        up_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_word,
  output logic             out_last
);

  logic             hold_valid_r;
  logic [2:0]       idx_r;
  logic [3:0]       hund_r, tens_r, ones_r;
  logic             out_valid_r;
  logic [WordW-1:0] out_word_r;
  logic             out_last_r;
  logic             out_load;
  logic             hold_done;
  logic [6:0]       ones_full;
  logic [2:0]       start_idx;
  logic [WordW-1:0] word;

  assign out_load  = !out_valid_r || out_ready;
  assign hold_done = hold_valid_r && out_load && (idx_r == IDX_LAST);
  assign up_ready  = !hold_valid_r || hold_done;

  assign ones_full = up_item.rem - 7'(up_item.tens) * 7'(DIV_10);
  assign start_idx = up_item.ge100 ? IDX_HUND : (up_item.ge10 ? IDX_TENS : IDX_ONES);

  always_comb begin
    case (idx_r)
      IDX_HUND: word = {SEL_HUNDREDS, seg_of(hund_r)};
      IDX_TENS: word = {SEL_TENS, seg_of(tens_r)};
      IDX_ONES: word = {SEL_ONES, seg_of(ones_r)};
      default:  word = WORD_ALL_OFF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= IDX_HUND;
    end else begin
      if (out_load) out_valid_r <= hold_valid_r;
      if (up_ready) hold_valid_r <= up_valid;
      if (up_ready && up_valid) begin
        idx_r <= start_idx;
      end else if (hold_valid_r && out_load) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hund_r <= up_item.hund;
      tens_r <= up_item.tens;
      ones_r <= ones_full[3:0];
    end
    if (out_load) begin
      out_word_r <= word;
      out_last_r <= (idx_r == IDX_LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/seven_segment_digit_scan.sv
// Top level of the three-digit multiplexed seven-segment scan driver.
// Depends on sdsc_pkg, sdsc_mod1000, sdsc_digits and sdsc_scan_out.
//
//   Channel  Direction  Payload                           Items
//   in_      slave      tdata[15:0] value                 one per value
//   out_     master     tdata[11:0] port_word, tlast      2, 4 or 6 per value
//
// An accepted value passes six pipeline stages (modulo 1000, hundreds, remainder, tens),
// a hold register and the output register before its first word appears. The output
// register emits one word per cycle while out_tready is high, so a value gives 2, 4 or
// 6 words (under 10, under 100, otherwise); that port sets the rate.
// Reset (rst_n low at a clock edge) empties every stage; no data register is cleared.
// A stall on out_tready backs up stage by stage through per-stage ready signals;
// nothing is dropped or repeated, and in_tready stays high while any stage has room.
module seven_segment_digit_scan import sdsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] port_word, [15:12] zero
  output logic        out_tlast
);

  // Handshake between the modulo stage and the digit split.
  logic      mod_valid;
  logic      mod_ready;
  mod_item_t mod_item;

  // Handshake between the digit split and the scan sequencer.
  logic      dig_valid;
  logic      dig_ready;
  dig_item_t dig_item;

  logic [WordW-1:0] port_word;

  // Value modulo 1000, computed with a scaled reciprocal and one correction.
  sdsc_mod1000 u_mod1000 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_value (in_tdata),
    .dn_valid (mod_valid),
    .dn_ready (mod_ready),
    .dn_item  (mod_item)
  );

  // Hundreds and tens digits; the ones digit is finished in the sequencer.
  sdsc_digits u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mod_valid),
    .up_ready (mod_ready),
    .up_item  (mod_item),
    .dn_valid (dig_valid),
    .dn_ready (dig_ready),
    .dn_item  (dig_item)
  );

  // Word sequencer: leading zeros are skipped by starting the scan at the tens or
  // ones position, and the closing all-off word carries tlast.
  sdsc_scan_out u_scan_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (dig_valid),
    .up_ready  (dig_ready),
    .up_item   (dig_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (port_word),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'b0000, port_word};

`ifndef ASSERT_OFF
  // The run always ends on a blanking word.
  a_last_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[11:0] == WORD_ALL_OFF)
    else $error("last word is not the all-off word");

  // Every word that lights something selects exactly one of the three digits.
  a_digit_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:0] != WORD_ALL_OFF |->
      out_tdata[11:8] == SEL_HUNDREDS || out_tdata[11:8] == SEL_TENS ||
      out_tdata[11:8] == SEL_ONES)
    else $error("digit word with a bad select code");

  // The correction step must leave the remainder below 1000.
  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    mod_valid |-> mod_item.rem < DIV_1000)
    else $error("remainder modulo 1000 out of range");

  // The digit split must produce decimal digits and a remainder below 100.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    dig_valid |-> dig_item.hund <= 4'd9 && dig_item.tens <= 4'd9 &&
      dig_item.rem < DIV_100)
    else $error("digit split out of range");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-digit seven-segment scan driver.
// Depends on sdsc_pkg and the seven_segment_digit_scan RTL; needs nothing else.
module tb;
  import sdsc_pkg::*;

  // Far above the length of the slowest correct run, so this only trips on a hang.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles left after the last word so that a stray extra word is still caught.
  localparam int TAIL_CYCLES = 16;
  // Chance in a hundred that a side idles in a given cycle.
  localparam int IDLE_PERCENT = 8;
  // Items accepted inside this window are sent and taken with no idling at all.
  localparam int QUIET_FIRST = 120;
  localparam int QUIET_LAST  = 200;
  localparam int RANDOM_VALUES = 320;
  localparam int MAX_REPORTS = 10;

  // One value waiting to be sent. When drain_first is set the sender holds it
  // back until every port word of the earlier values has come out.
  typedef struct {
    logic [ValueW-1:0] value;
    bit                drain_first;
  } display_value_t;

  // One port word the display should see, with its end-of-scan mark.
  typedef struct {
    logic [WordW-1:0] port_word;
    logic             last;
  } scan_word_t;

  // Active-low segment patterns (dp,g,f,e,d,c,b,a) for the digits 0 to 9.
  localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [15:0] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [11:0] port_word, [15:12] zero
  logic        out_tlast;

  display_value_t values_to_send[$];
  scan_word_t     expected_scan[$];

  // Registered copy of "some port word is still owed", so that the sender
  // reads a value that does not depend on the order of the clocked blocks.
  logic results_pending = 1'b0;
  int   values_accepted = 0;
  int   values_total    = 0;
  int   mismatch_count  = 0;
  int   cycle_count     = 0;

  seven_segment_digit_scan u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Works out the scan of one value: the shown digits from hundreds down to
  // ones, each followed by an all-off word. Leading zeros stay dark, and values
  // of a thousand or more lose their thousands so all three digits are shown.
  function automatic void predict_scan_words(input logic [ValueW-1:0] value);
    int         remainder;
    int         digit_hund;
    int         digit_tens;
    int         digit_ones;
    scan_word_t sw;
    remainder  = int'(value) % 1000;
    digit_hund = remainder / 100;
    digit_tens = (remainder % 100) / 10;
    digit_ones = int'(value) % 10;
    sw.last = 1'b0;
    if (value >= 100) begin
      sw.port_word = {SEL_HUNDREDS, DIGIT_SEGMENTS[digit_hund]};
      expected_scan.push_back(sw);
      sw.port_word = WORD_ALL_OFF;
      expected_scan.push_back(sw);
    end
    if (value >= 10) begin
      sw.port_word = {SEL_TENS, DIGIT_SEGMENTS[digit_tens]};
      expected_scan.push_back(sw);
      sw.port_word = WORD_ALL_OFF;
      expected_scan.push_back(sw);
    end
    sw.port_word = {SEL_ONES, DIGIT_SEGMENTS[digit_ones]};
    expected_scan.push_back(sw);
    // Only the closing all-off word of the scan carries the end mark.
    sw.port_word = WORD_ALL_OFF;
    sw.last      = 1'b1;
    expected_scan.push_back(sw);
  endfunction

  // Sender. The valid item is held until it is taken; a new one is offered
  // only when the slot is free and the random idling allows it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        values_accepted <= values_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (values_to_send.size() != 0 &&
            ((values_accepted >= QUIET_FIRST && values_accepted < QUIET_LAST) ||
             $urandom_range(99) >= IDLE_PERCENT) &&
            (!values_to_send[0].drain_first || (!in_tvalid && !results_pending))) begin
          in_tvalid <= 1'b1;
          in_tdata  <= values_to_send[0].value;
          values_to_send.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker. Accepted input items are turned into expected port
  // words here, and every accepted output word is compared with the oldest one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_scan_words(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (expected_scan.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected port word: tdata=%h tlast=%b", out_tdata, out_tlast);
          end
        end else begin
          if (out_tdata !== {4'b0000, expected_scan[0].port_word} ||
              out_tlast !== expected_scan[0].last) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("port word mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                       {4'b0000, expected_scan[0].port_word}, expected_scan[0].last,
                       out_tdata, out_tlast);
            end
          end
          expected_scan.pop_front();
        end
      end
      results_pending <= (expected_scan.size() != 0);
      out_tready <= (values_accepted >= QUIET_FIRST && values_accepted < QUIET_LAST) ||
                    ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog against a block that never finishes its work.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus and the end of the run.
  initial begin
    display_value_t item;
    logic [ValueW-1:0] directed_values[$];
    directed_values = '{
      16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100, 16'd101, 16'd110, 16'd999,
      16'd1000, 16'd1001, 16'd1009, 16'd1010, 16'd1099, 16'd1100, 16'd65535, 16'd65000,
      16'd12345, 16'd500, 16'd50, 16'd5, 16'hAAAA, 16'h5555, 16'h8000
    };

    // Directed part: each blanking case, zero, the thousands wrap and both
    // values of every input bit. One item waits for the block to drain.
    foreach (directed_values[i]) begin
      item.value       = directed_values[i];
      item.drain_first = (i == 10);
      values_to_send.push_back(item);
    end

    // Random part: values up to 9, 99 and 999, full 16-bit values, and multiples of a
    // thousand plus a ones digit, each kind picked with equal chance.
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      case ($urandom_range(4))
        0: item.value = 16'($urandom_range(9));
        1: item.value = 16'($urandom_range(99));
        2: item.value = 16'($urandom_range(999));
        3: item.value = 16'(1000 * $urandom_range(65) + $urandom_range(9));
        default: item.value = 16'($urandom_range(65535));
      endcase
      item.drain_first = (n % 64 == 63);
      values_to_send.push_back(item);
    end
    values_total = values_to_send.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item is taken and every port word has come out.
    @(posedge clk);
    while (values_accepted < values_total || results_pending) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_scan.size() != 0) begin
      $display("%0d expected port words never arrived", expected_scan.size());
    end
    if (mismatch_count == 0 && expected_scan.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: seven_segment_digit_scan.f
rtl/sdsc_pkg.sv
rtl/sdsc_mod1000.sv
rtl/sdsc_digits.sv
rtl/sdsc_scan_out.sv
rtl/seven_segment_digit_scan.sv
tb/tb.sv
